/* sv/rhh_pkg.sv */
// Shared types and constants for the Robin Hood insert core.
// Used by robin_hood_hash_table_insert_core and its checker; no dependencies.
package rhh_pkg;

  localparam int TABLE_DEPTH_DEF = 1024;

  localparam int CFG_W      = 11;
  localparam int KEY_W      = 64;
  localparam int CODE_W     = 32;
  localparam int DIST_W     = 16;
  localparam int SLOT_W     = 10;
  localparam int OUT_DIST_W = 10;
  localparam int STATUS_W   = 2;
  localparam int BIT_CNT_W  = $clog2(KEY_W);

  localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 11'd1024;

  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_READ   = 1'b1
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_WALK_RD,
    S_WALK_CHK,
    S_RD_WAIT,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [DIST_W-1:0] pdist;
    logic [CODE_W-1:0] code;
  } slot_t;

endpackage

/* sv/robin_hood_hash_table_insert_core.sv */
// Robin Hood open-addressed code table: insert with linear probing and read.
// Slot memory is a single-port-write, registered-read array; depends on rhh_pkg.
//
//   channel  | handshake          | payload
//   ---------+--------------------+----------------------------------------------
//   in_      | in_valid/in_stall  | opcode, hash_key, code, slot
//   out_     | out_valid/out_stall| status, slot_index, code_out, distance_out
//   cfg_     | cfg_wr_en          | cfg_wr_data (table_size)
//
// An insert divides hash_key by the size serially, one bit a cycle, then scans for the
// first empty slot and walks from the home slot swapping; a scan probe only reads the slot
// memory, and a walk probe reads it and writes the slot when it places or swaps.
// Reset: a clearing pass over all TABLE_DEPTH slots zeroes the memory; in_stall is high.
// One item is in work at a time; a finished result waits in the output register
// while the next beat is accepted, and a stalled result holds the next one in FIN.
module robin_hood_hash_table_insert_core #(
  parameter int TABLE_DEPTH = rhh_pkg::TABLE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [rhh_pkg::CFG_W-1:0]     cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_opcode,
  input  logic [rhh_pkg::KEY_W-1:0]     in_hash_key,
  input  logic [rhh_pkg::CODE_W-1:0]    in_code,
  input  logic [rhh_pkg::SLOT_W-1:0]    in_slot,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rhh_pkg::STATUS_W-1:0]  out_status,
  output logic [rhh_pkg::SLOT_W-1:0]    out_slot_index,
  output logic [rhh_pkg::CODE_W-1:0]    out_code_out,
  output logic [rhh_pkg::OUT_DIST_W-1:0] out_distance_out
);
  import rhh_pkg::*;

  localparam int AW     = $clog2(TABLE_DEPTH);
  localparam int SIZE_W = $clog2(TABLE_DEPTH + 1);

  // slot memory
  slot_t            mem [TABLE_DEPTH];
  slot_t            rd_data_r;
  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_wa, mem_ra;
  slot_t            mem_wd;

  state_t           state_r, state_nxt;
  logic [AW-1:0]    clr_addr_r, clr_addr_nxt;
  logic [CFG_W-1:0] size_r;
  logic [SIZE_W-1:0] count_r, count_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [BIT_CNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [SIZE_W-1:0] rem_r, rem_nxt;
  logic [AW-1:0]    pos_r, pos_nxt;
  logic [AW-1:0]    home_r, home_nxt;
  logic [SIZE_W-1:0] steps_r, steps_nxt;
  logic [CODE_W-1:0] carried_r, carried_nxt;
  logic [DIST_W:0]  dist_r, dist_nxt;
  logic [CODE_W-1:0] new_code_r, new_code_nxt;
  logic             placed_r, placed_nxt;
  logic [AW-1:0]    rest_r, rest_nxt;
  logic [DIST_W-1:0] rest_dist_r, rest_dist_nxt;

  status_t          res_status_r, res_status_nxt;
  logic [SLOT_W-1:0] res_slot_r, res_slot_nxt;
  logic [CODE_W-1:0] res_code_r, res_code_nxt;
  logic [OUT_DIST_W-1:0] res_dist_r, res_dist_nxt;

  logic             out_valid_r, out_valid_nxt;
  status_t          out_status_r, out_status_nxt;
  logic [SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic [CODE_W-1:0] out_code_r, out_code_nxt;
  logic [OUT_DIST_W-1:0] out_dist_r, out_dist_nxt;

  // effective size, clamped to 1..TABLE_DEPTH
  logic [31:0]      size_ext;
  logic [SIZE_W-1:0] eff_n;
  logic [SIZE_W:0]  rem_shift;
  logic [SIZE_W-1:0] rem_step;
  logic [SIZE_W-1:0] pos_inc;
  logic [AW-1:0]    pos_adv;
  logic [SIZE_W-1:0] steps_inc;

  always_comb begin
    size_ext = 32'(size_r);
    if (size_r == '0) begin
      eff_n = SIZE_W'(1);
    end else if (size_ext > 32'(TABLE_DEPTH)) begin
      eff_n = SIZE_W'(TABLE_DEPTH);
    end else begin
      eff_n = SIZE_W'(size_ext);
    end
  end

  // one restoring step of hash_key mod size
  assign rem_shift = {rem_r, key_r[KEY_W-1]};
  assign rem_step  = (rem_shift >= {1'b0, eff_n}) ? SIZE_W'(rem_shift - {1'b0, eff_n})
                                                  : SIZE_W'(rem_shift);

  assign pos_inc   = SIZE_W'(pos_r) + SIZE_W'(1);
  assign pos_adv   = (pos_inc >= eff_n) ? '0 : AW'(pos_inc);
  assign steps_inc = steps_r + SIZE_W'(1);

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r  <= '0;
      size_r      <= CFG_SIZE_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      clr_addr_r  <= clr_addr_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        size_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    bit_cnt_r    <= bit_cnt_nxt;
    rem_r        <= rem_nxt;
    pos_r        <= pos_nxt;
    home_r       <= home_nxt;
    steps_r      <= steps_nxt;
    carried_r    <= carried_nxt;
    dist_r       <= dist_nxt;
    new_code_r   <= new_code_nxt;
    placed_r     <= placed_nxt;
    rest_r       <= rest_nxt;
    rest_dist_r  <= rest_dist_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_code_r   <= res_code_nxt;
    res_dist_r   <= res_dist_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_code_r   <= out_code_nxt;
    out_dist_r   <= out_dist_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    count_nxt      = count_r;
    key_nxt        = key_r;
    bit_cnt_nxt    = bit_cnt_r;
    rem_nxt        = rem_r;
    pos_nxt        = pos_r;
    home_nxt       = home_r;
    steps_nxt      = steps_r;
    carried_nxt    = carried_r;
    dist_nxt       = dist_r;
    new_code_nxt   = new_code_r;
    placed_nxt     = placed_r;
    rest_nxt       = rest_r;
    rest_dist_nxt  = rest_dist_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_code_nxt   = res_code_r;
    res_dist_nxt   = res_dist_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_code_nxt   = out_code_r;
    out_dist_nxt   = out_dist_r;
    mem_we         = 1'b0;
    mem_wa         = pos_r;
    mem_wd         = '0;
    mem_re         = 1'b0;
    mem_ra         = pos_r;

    unique case (state_r)
      S_CLEAR: begin
        mem_we       = 1'b1;
        mem_wa       = clr_addr_r;
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(TABLE_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          if (in_opcode == OP_READ) begin
            res_slot_nxt = in_slot;
            if (32'(in_slot) >= 32'(eff_n)) begin
              res_status_nxt = ST_RANGE;
              res_code_nxt   = '0;
              res_dist_nxt   = '0;
              state_nxt      = S_FIN;
            end else begin
              mem_re    = 1'b1;
              mem_ra    = AW'(in_slot);
              state_nxt = S_RD_WAIT;
            end
          end else if (in_code == '0 || count_r >= eff_n) begin
            res_status_nxt = ST_FULL;
            res_slot_nxt   = '0;
            res_code_nxt   = '0;
            res_dist_nxt   = '0;
            state_nxt      = S_FIN;
          end else begin
            key_nxt      = in_hash_key;
            new_code_nxt = in_code;
            rem_nxt      = '0;
            bit_cnt_nxt  = '0;
            state_nxt    = S_DIV;
          end
        end
      end

      S_RD_WAIT: begin
        res_status_nxt = ST_OK;
        res_code_nxt   = rd_data_r.code;
        res_dist_nxt   = OUT_DIST_W'(rd_data_r.pdist);
        state_nxt      = S_FIN;
      end

      S_DIV: begin
        key_nxt     = {key_r[KEY_W-2:0], 1'b0};
        rem_nxt     = rem_step;
        bit_cnt_nxt = bit_cnt_r + BIT_CNT_W'(1);
        if (bit_cnt_r == BIT_CNT_W'(KEY_W - 1)) begin
          pos_nxt   = AW'(rem_step);
          home_nxt  = AW'(rem_step);
          steps_nxt = '0;
          state_nxt = S_SCAN_RD;
        end
      end

      // read-only pass: make sure an empty slot exists before any swap
      S_SCAN_RD: begin
        mem_re    = 1'b1;
        state_nxt = S_SCAN_CHK;
      end

      S_SCAN_CHK: begin
        if (rd_data_r.code == '0) begin
          pos_nxt     = home_r;
          carried_nxt = new_code_r;
          dist_nxt    = '0;
          placed_nxt  = 1'b0;
          state_nxt   = S_WALK_RD;
        end else if (steps_inc == eff_n) begin
          res_status_nxt = ST_FULL;
          res_slot_nxt   = '0;
          res_code_nxt   = '0;
          res_dist_nxt   = '0;
          state_nxt      = S_FIN;
        end else begin
          steps_nxt = steps_inc;
          pos_nxt   = pos_adv;
          state_nxt = S_SCAN_RD;
        end
      end

      S_WALK_RD: begin
        mem_re    = 1'b1;
        state_nxt = S_WALK_CHK;
      end

      S_WALK_CHK: begin
        if (rd_data_r.code == '0) begin
          mem_we         = 1'b1;
          mem_wd.code    = carried_r;
          mem_wd.pdist   = DIST_W'(dist_r);
          res_status_nxt = ST_OK;
          res_code_nxt   = new_code_r;
          if (placed_r) begin
            res_slot_nxt = SLOT_W'(rest_r);
            res_dist_nxt = OUT_DIST_W'(rest_dist_r);
          end else begin
            res_slot_nxt = SLOT_W'(pos_r);
            res_dist_nxt = OUT_DIST_W'(dist_r);
          end
          count_nxt = count_r + SIZE_W'(1);
          state_nxt = S_FIN;
        end else begin
          // take the slot of a resident closer to its home, carry it on
          if ({1'b0, rd_data_r.pdist} < dist_r) begin
            mem_we       = 1'b1;
            mem_wd.code  = carried_r;
            mem_wd.pdist = DIST_W'(dist_r);
            if (!placed_r) begin
              rest_nxt      = pos_r;
              rest_dist_nxt = DIST_W'(dist_r);
              placed_nxt    = 1'b1;
            end
            carried_nxt = rd_data_r.code;
            dist_nxt    = {1'b0, rd_data_r.pdist} + (DIST_W + 1)'(1);
          end else begin
            dist_nxt = dist_r + (DIST_W + 1)'(1);
          end
          pos_nxt   = pos_adv;
          state_nxt = S_WALK_RD;
        end
      end

      S_FIN: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt   = res_slot_r;
          out_code_nxt   = res_code_r;
          out_dist_nxt   = res_dist_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_status       = STATUS_W'(out_status_r);
  assign out_slot_index   = out_slot_r;
  assign out_code_out     = out_code_r;
  assign out_distance_out = out_dist_r;

endmodule

/* sv/rhh_checker.sv */
// Port-level checks for robin_hood_hash_table_insert_core, bound into every instance of the core.
// Depends on rhh_pkg.
module rhh_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [rhh_pkg::STATUS_W-1:0]   out_status,
  input logic [rhh_pkg::SLOT_W-1:0]     out_slot_index,
  input logic [rhh_pkg::CODE_W-1:0]     out_code_out,
  input logic [rhh_pkg::OUT_DIST_W-1:0] out_distance_out
);
  import rhh_pkg::*;

  // memory clear runs after reset, so no beat is taken right away
  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input taken during clearing pass");

  // one item in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second beat accepted while busy");

  // no result can appear the cycle after a beat is taken
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result appeared too early");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_slot_index) && $stable(out_code_out) && $stable(out_distance_out))
    else $error("stalled result changed");

endmodule

bind robin_hood_hash_table_insert_core rhh_checker u_rhh_checker (.*);

/* test/robin_hood_hash_table_insert_core_tb.sv */
// Self-checking testbench for robin_hood_hash_table_insert_core: a directed table, then random
// phases across table sizes, each result checked against a slot-level Robin Hood table model
// or a value given in the directed table. Depends on rhh_pkg and the core RTL only.
module robin_hood_hash_table_insert_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rhh_pkg::*;

  localparam int TABLE_DEPTH = TABLE_DEPTH_DEF;
  localparam int QUIET_LIMIT = 20000;

  typedef struct {
    status_t          st;
    logic [SLOT_W-1:0] si;
    logic [CODE_W-1:0] co;
    logic [OUT_DIST_W-1:0] di;
  } result_t;

  typedef struct {
    bit                is_size;
    logic [CFG_W-1:0]  size;
    opcode_t           op;
    logic [KEY_W-1:0]  key;
    logic [CODE_W-1:0] code;
    logic [SLOT_W-1:0] slot;
    bit                typed;
    result_t           want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_opcode = 1'b0;
  logic [KEY_W-1:0] in_hash_key = '0;
  logic [CODE_W-1:0] in_code = '0;
  logic [SLOT_W-1:0] in_slot = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [SLOT_W-1:0] out_slot_index;
  logic [CODE_W-1:0] out_code_out;
  logic [OUT_DIST_W-1:0] out_distance_out;

  // Model state: slot contents, accepted insert count, size register
  slot_t table_mem [TABLE_DEPTH];
  int unsigned fill_count = 0;
  logic [CFG_W-1:0] size_reg = CFG_SIZE_RESET;

  result_t awaited_results [$];
  plan_row_t plan [$];
  int mismatches = 0;
  int quiet_cycles = 0;
  int stall_run = 0;
  bit calm = 1'b0;

  robin_hood_hash_table_insert_core uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_hash_key     (in_hash_key),
    .in_code         (in_code),
    .in_slot         (in_slot),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_slot_index  (out_slot_index),
    .out_code_out    (out_code_out),
    .out_distance_out(out_distance_out)
  );

  initial forever #1 clk = ~clk;

  function automatic int live_size();
    if (size_reg == '0) return 1;
    if (size_reg > TABLE_DEPTH) return TABLE_DEPTH;
    return int'(size_reg);
  endfunction

  // Compute the outcome of one beat and commit any table update.
  function automatic result_t table_outcome(opcode_t op, logic [KEY_W-1:0] key,
                                            logic [CODE_W-1:0] code, logic [SLOT_W-1:0] slot);
    result_t r;
    slot_t trial [TABLE_DEPTH];
    slot_t evicted;
    logic [CODE_W-1:0] carried;
    int n, pos, probe_dist, rest, rest_dist, step;
    bit placed, done;
    n = live_size();
    r = '{ST_FULL, '0, '0, '0};
    if (op == OP_READ) begin
      if (int'(slot) >= n) r = '{ST_RANGE, slot, '0, '0};
      else r = '{ST_OK, slot, table_mem[slot].code, table_mem[slot].pdist[OUT_DIST_W-1:0]};
      return r;
    end
    if (code == '0 || fill_count >= n) return r;
    trial = table_mem;
    pos = int'(key % 64'(n));
    probe_dist = 0;
    carried = code;
    placed = 1'b0;
    done = 1'b0;
    rest = 0;
    rest_dist = 0;
    for (step = 0; step < n && !done; step++) begin
      if (trial[pos].code == '0) begin
        trial[pos].code = carried;
        trial[pos].pdist = DIST_W'(probe_dist);
        if (!placed) begin
          rest = pos;
          rest_dist = probe_dist;
          placed = 1'b1;
        end
        done = 1'b1;
      end else begin
        // Rich resident yields its slot; carry it on
        if (int'(trial[pos].pdist) < probe_dist) begin
          evicted = trial[pos];
          trial[pos].code = carried;
          trial[pos].pdist = DIST_W'(probe_dist);
          if (!placed) begin
            rest = pos;
            rest_dist = probe_dist;
            placed = 1'b1;
          end
          carried = evicted.code;
          probe_dist = int'(evicted.pdist);
        end
        probe_dist++;
        pos = (pos + 1 >= n) ? 0 : pos + 1;
      end
    end
    if (!done) return r;
    table_mem = trial;
    fill_count++;
    r = '{ST_OK, SLOT_W'(rest), code, OUT_DIST_W'(rest_dist)};
    return r;
  endfunction

  function automatic void add_beat(opcode_t op, logic [KEY_W-1:0] key, logic [CODE_W-1:0] code,
                                   logic [SLOT_W-1:0] slot, bit typed = 1'b0,
                                   status_t st = ST_OK, logic [SLOT_W-1:0] si = '0,
                                   logic [CODE_W-1:0] co = '0, logic [OUT_DIST_W-1:0] di = '0);
    plan_row_t row;
    row.is_size = 1'b0;
    row.size = '0;
    row.op = op;
    row.key = key;
    row.code = code;
    row.slot = slot;
    row.typed = typed;
    row.want = '{st, si, co, di};
    plan.push_back(row);
  endfunction

  function automatic void add_size(logic [CFG_W-1:0] v);
    plan_row_t row;
    row.is_size = 1'b1;
    row.size = v;
    row.op = OP_READ;
    row.key = '0;
    row.code = '0;
    row.slot = '0;
    row.typed = 1'b0;
    row.want = '{ST_OK, '0, '0, '0};
    plan.push_back(row);
  endfunction

  task automatic flag_field(string field, logic [63:0] got, logic [63:0] want);
    $display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, field, got, want);
    mismatches++;
  endtask

  task automatic hold_valid_low(int cycles);
    repeat (cycles) @(negedge clk) in_valid <= 1'b0;
  endtask

  task automatic send_beat(opcode_t op, logic [KEY_W-1:0] key, logic [CODE_W-1:0] code,
                           logic [SLOT_W-1:0] slot, bit typed, result_t want);
    result_t predicted;
    @(negedge clk);
    in_valid <= 1'b1;
    in_opcode <= op;
    in_hash_key <= key;
    in_code <= code;
    in_slot <= slot;
    do @(posedge clk); while (in_stall);
    predicted = table_outcome(op, key, code, slot);
    if (typed) awaited_results.push_back(want);
    else awaited_results.push_back(predicted);
  endtask

  // Drain, then write the size register while the core is idle.
  task automatic write_size(logic [CFG_W-1:0] v);
    @(negedge clk) in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    size_reg = v;
    @(negedge clk) cfg_wr_en <= 1'b0;
  endtask

  task automatic run_phase(logic [CFG_W-1:0] size, int beats, int insert_pct, bit steady);
    opcode_t op;
    logic [KEY_W-1:0] key;
    logic [CODE_W-1:0] code;
    logic [SLOT_W-1:0] slot;
    result_t none;
    int n;
    write_size(size);
    calm = steady;
    n = live_size();
    none = '{ST_OK, '0, '0, '0};
    repeat (beats) begin
      if (!steady && $urandom_range(0, 3) == 0) hold_valid_low($urandom_range(1, 15));
      op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_READ;
      // Bias some keys toward a few home slots to force collisions
      case ($urandom_range(0, 4))
        0: key = 64'($urandom_range(0, 2 * n));
        1: key = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, n));
        default: key = {$urandom, $urandom};
      endcase
      code = $urandom;
      case ($urandom_range(0, 39))
        0: code = '0;
        1: code = '1;
        default: if (code == '0) code = 1;
      endcase
      slot = $urandom_range(0, 1) ? SLOT_W'($urandom) : SLOT_W'($urandom_range(0, n - 1));
      send_beat(op, key, code, slot, 1'b0, none);
    end
  endtask

  // Output side: random stall bursts between clear runs
  always @(negedge clk) begin
    if (calm) begin
      out_stall <= 1'b0;
    end else if (stall_run != 0) begin
      stall_run <= stall_run - 1;
    end else if (!out_stall && $urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      stall_run <= $urandom_range(0, 14);
    end else begin
      out_stall <= 1'b0;
      stall_run <= $urandom_range(0, 30);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        flag_field("beat with nothing pending", 64'(out_code_out), '0);
      end else begin
        want = awaited_results.pop_front();
        if (out_status !== want.st)
          flag_field("status", 64'(out_status), 64'(want.st));
        if (out_slot_index !== want.si)
          flag_field("slot_index", 64'(out_slot_index), 64'(want.si));
        if (out_code_out !== want.co)
          flag_field("code_out", 64'(out_code_out), 64'(want.co));
        if (out_distance_out !== want.di)
          flag_field("distance_out", 64'(out_distance_out), 64'(want.di));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    foreach (table_mem[i]) table_mem[i] = '0;

    // Reset state, zero code, tiny table, full and range cases, then a swap at size 4
    add_beat(OP_READ, '0, '0, 10'd0, 1'b1, ST_OK, 10'd0, '0, '0);
    add_beat(OP_READ, '0, '0, 10'd1023, 1'b1, ST_OK, 10'd1023, '0, '0);
    add_beat(OP_INSERT, 64'd5, '0, '0, 1'b1, ST_FULL, '0, '0, '0);
    add_size(11'd0);
    add_beat(OP_READ, '0, '0, 10'd1, 1'b1, ST_RANGE, 10'd1, '0, '0);
    add_beat(OP_INSERT, '1, '1, '0, 1'b1, ST_OK, 10'd0, '1, '0);
    add_beat(OP_INSERT, '0, 32'd1, '0, 1'b1, ST_FULL, '0, '0, '0);
    add_beat(OP_READ, '0, '0, 10'd0, 1'b1, ST_OK, 10'd0, '1, '0);
    add_beat(OP_READ, '0, '0, 10'd1023, 1'b1, ST_RANGE, 10'd1023, '0, '0);
    add_size(11'd4);
    add_beat(OP_INSERT, 64'd4, 32'd2, '0);
    add_beat(OP_INSERT, 64'd1, 32'd3, '0);
    add_beat(OP_INSERT, 64'd0, 32'd4, '0);
    add_beat(OP_INSERT, 64'd3, 32'd9, '0, 1'b1, ST_FULL, '0, '0, '0);
    add_beat(OP_READ, '0, '0, 10'd2);
    add_beat(OP_READ, '0, '0, 10'd3);
    add_beat(OP_READ, '0, '0, 10'd4, 1'b1, ST_RANGE, 10'd4, '0, '0);
    add_size(11'd2047);
    add_beat(OP_READ, '0, '0, 10'd1023, 1'b1, ST_OK, 10'd1023, '0, '0);
    add_beat(OP_READ, '0, '0, 10'd3);

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_size) write_size(plan[i].size);
      else send_beat(plan[i].op, plan[i].key, plan[i].code, plan[i].slot, plan[i].typed,
                     plan[i].want);
    end

    // Step the table through several sizes; the insert count carries across sizes
    run_phase(11'd16, 120, 70, 1'b0);
    run_phase(11'd100, 250, 60, 1'b0);
    run_phase(11'd0, 60, 50, 1'b0);
    run_phase(11'd1000, 700, 75, 1'b0);
    run_phase(11'd2047, 420, 90, 1'b0);
    run_phase(11'd1024, 250, 30, 1'b1);

    @(negedge clk) in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
